// File: sv/fmod_pkg.sv
// Package for the single-precision fmod block: constants, queue entry type, FSM states.
// No dependencies.
`default_nettype none
package fmod_pkg;
    localparam logic [31:0] SIGN_BIT       = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK       = 32'h7fff_ffff;
    localparam logic [31:0] INF_PATTERN    = 32'h7f80_0000;
    localparam logic [31:0] LARGEST_FINITE = 32'h7f7f_ffff;
    localparam logic [31:0] QUIET_BIT      = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN    = 32'hffc0_0000;
    localparam int          QDEPTH         = 2;
    localparam int          QW             = $clog2(QDEPTH);

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic        done;     // result already known
        logic [31:0] result;   // valid when done
        logic        sx;
        logic [9:0]  ex;       // signed exponents, offset range fits 10 bits
        logic [9:0]  ey;
        logic [23:0] mx;
        logic [23:0] my;
    } fmod_job_t;

    typedef enum logic [1:0] {
        B_IDLE, B_LOOP, B_NORM, B_PACK
    } back_state_t;

    // Position of the highest set bit of a nonzero 23-bit fraction.
    function automatic logic [4:0] top_bit(input logic [22:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 23; i++)
            if (v[i]) p = 5'(i);
        return p;
    endfunction
endpackage
`default_nettype wire

// File: sv/fmod_front.sv
// Front part: classifies an item, handles special cases, unpacks operands.
// Depends on fmod_pkg.
`default_nettype none
module fmod_front import fmod_pkg::*; (
    input  wire logic [31:0] dividend_bits,
    input  wire logic [31:0] divisor_bits,
    output fmod_job_t        job
);
    logic [31:0] hx, hy;
    logic [4:0]  tx, ty;

    always_comb
    begin
        hx = dividend_bits & MAG_MASK;
        hy = divisor_bits & MAG_MASK;
        tx = top_bit(hx[22:0]);
        ty = top_bit(hy[22:0]);
        job = '0;
        job.sx = dividend_bits[31];
        if (hy == '0 || hx > LARGEST_FINITE || hy > INF_PATTERN)
        begin
            job.done = 1'b1;
            if (hx > INF_PATTERN)      job.result = dividend_bits | QUIET_BIT;
            else if (hy > INF_PATTERN) job.result = divisor_bits | QUIET_BIT;
            else                       job.result = DEFAULT_NAN;
        end
        else if (hx < hy)
        begin
            job.done = 1'b1;
            job.result = dividend_bits;
        end
        else if (hx == hy)
        begin
            job.done = 1'b1;
            job.result = dividend_bits & SIGN_BIT;
        end
        // Exponents kept biased-by-127 style: normal e = field, subnormal e = top-22.
        if (hx[30:23] == 8'd0)
        begin
            job.ex = 10'(tx) - 10'd22;
            job.mx = 24'(hx[22:0]) << (5'd23 - tx);
        end
        else
        begin
            job.ex = 10'(hx[30:23]);
            job.mx = {1'b1, hx[22:0]};
        end
        if (hy[30:23] == 8'd0)
        begin
            job.ey = 10'(ty) - 10'd22;
            job.my = 24'(hy[22:0]) << (5'd23 - ty);
        end
        else
        begin
            job.ey = 10'(hy[30:23]);
            job.my = {1'b1, hy[22:0]};
        end
    end
endmodule
`default_nettype wire

// File: sv/fmod_queue.sv
// Short FIFO of jobs between front and back parts.
// Depends on fmod_pkg.
`default_nettype none
module fmod_queue import fmod_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fmod_job_t din,
    input  wire logic      pop,
    output fmod_job_t      dout,
    output logic           empty,
    output logic           full
);
    fmod_job_t     mem_reg [QDEPTH];
    logic [QW:0]   wp_reg, rp_reg;

    assign empty = (wp_reg == rp_reg);
    assign full  = (wp_reg[QW-1:0] == rp_reg[QW-1:0]) && (wp_reg[QW] != rp_reg[QW]);
    assign dout  = mem_reg[rp_reg[QW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg[QW-1:0]] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + (QW+1)'(1);
            if (pop)  rp_reg <= rp_reg + (QW+1)'(1);
        end
    end
endmodule
`default_nettype wire

// File: sv/fmod_back.sv
// Back part: shift-and-subtract loop, renormalize, pack the result.
// Depends on fmod_pkg.
`default_nettype none
module fmod_back import fmod_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fmod_job_t   job,
    input  wire logic        avail,
    output logic             take,
    output logic             done,
    output logic [31:0]      remainder_bits
);
    back_state_t state_reg, state_next;
    logic [24:0] mx_reg, mx_next;
    logic [23:0] my_reg, my_next;
    logic [9:0]  n_reg, n_next, e_reg, e_next;
    logic        sx_reg, sx_next;
    logic [31:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic [24:0] diff;
    logic [9:0]  sh;

    assign done = done_reg;
    assign remainder_bits = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        n_reg   <= n_next;
        e_reg   <= e_next;
        sx_reg  <= sx_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mx_next = mx_reg; my_next = my_reg; n_next = n_reg; e_next = e_reg;
        sx_next = sx_reg; res_next = res_reg;
        done_next = 1'b0;
        take = 1'b0;
        diff = mx_reg - 25'(my_reg);
        sh = 10'd1 - e_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (avail)
                begin
                    take = 1'b1;
                    sx_next = job.sx;
                    if (job.done)
                    begin
                        res_next = job.result;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        mx_next = 25'(job.mx);
                        my_next = job.my;
                        n_next  = job.ex - job.ey;
                        e_next  = job.ey;
                        state_next = B_LOOP;
                    end
                end
            end
            B_LOOP:
            begin
                // one quotient bit per cycle; final step when count hits zero
                if (n_reg == 10'd0)
                begin
                    if (!diff[24]) mx_next = diff;
                    if (!diff[24] ? (diff == '0) : (mx_reg == '0))
                    begin
                        res_next = {sx_reg, 31'd0};
                        done_next = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                        state_next = B_NORM;
                end
                else if (diff[24])
                begin
                    mx_next = mx_reg << 1;
                    n_next = n_reg - 10'd1;
                end
                else if (diff == '0)
                begin
                    res_next = {sx_reg, 31'd0};
                    done_next = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    mx_next = diff << 1;
                    n_next = n_reg - 10'd1;
                end
            end
            B_NORM:
            begin
                if (mx_reg[23]) state_next = B_PACK;
                else
                begin
                    mx_next = mx_reg << 1;
                    e_next = e_reg - 10'd1;
                end
            end
            B_PACK:
            begin
                // e_reg is biased; below 1 means subnormal
                if (!e_reg[9] && e_reg != 10'd0)
                    res_next = {sx_reg, e_reg[7:0], mx_reg[22:0]};
                else if (sh > 10'd31)
                    res_next = {sx_reg, 31'd0};
                else
                    res_next = {sx_reg, 31'(mx_reg[23:0] >> sh[4:0])};
                done_next = 1'b1;
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/fp32_remainder_fmod.sv
// Single-precision fmod. Special cases take their result from the front part; other items
// pass a take step, one quotient bit per cycle over the exponent difference plus a final
// step, renormalize steps and one pack step. The back part ends each item before taking
// the next. busy rises while the 2-entry job queue is full. Reset is asynchronous,
// active low; it empties the queue and idles the back part. The receiver cannot stall done.
`default_nettype none
module fp32_remainder_fmod import fmod_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] dividend_bits,
    input  wire logic [31:0] divisor_bits,
    output logic             done,
    output logic [31:0]      remainder_bits
);
    fmod_job_t fjob, qjob;
    logic empty, full, take;

    // classify and unpack in the front part
    fmod_front u_front (.dividend_bits, .divisor_bits, .job(fjob));

    assign busy = full;

    // hold jobs until the back part is free
    fmod_queue u_queue (
        .clk, .rst_n, .push(start && !full), .din(fjob),
        .pop(take), .dout(qjob), .empty, .full
    );

    // advance the remainder loop
    fmod_back u_back (
        .clk, .rst_n, .job(qjob), .avail(!empty), .take,
        .done, .remainder_bits
    );
endmodule
`default_nettype wire

// File: sv/fmod_checker.sv
// Port-level checker for fp32_remainder_fmod, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module fmod_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] remainder_bits
);
    a_no_x_done: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(done))
        else $error("done unknown");
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item");
    a_res_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(remainder_bits))
        else $error("result unknown");
endmodule
bind fp32_remainder_fmod fmod_checker u_chk (.clk, .rst_n, .start, .busy, .done,
    .remainder_bits);
`default_nettype wire

// File: tb/tb_fp32_remainder_fmod.sv
// Testbench for fp32_remainder_fmod: drives operand pairs through the start/busy
// handshake and checks every remainder against a local fmod predictor.
// Depends on fmod_pkg and fp32_remainder_fmod.
`timescale 1ns / 1ps
`default_nettype none
module tb_fp32_remainder_fmod import fmod_pkg::*;;

    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam int  DRAIN_CYCLES = 400;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } operand_pair_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] dividend_bits;
    logic [31:0] divisor_bits;
    logic        done;
    logic [31:0] remainder_bits;

    operand_pair_t pending_pairs[$];
    logic [31:0]   expected_remainders[$];
    int            mismatch_count;
    int            cycle_count;
    int            sender_idle_pct;

    fp32_remainder_fmod dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .dividend_bits  (dividend_bits),
        .divisor_bits   (divisor_bits),
        .done           (done),
        .remainder_bits (remainder_bits)
    );

    // Clock: 6 ns high, 6 ns low.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Split a finite nonzero magnitude into unbiased exponent and 24-bit significand;
    // subnormals are normalized here so the division loop never sees them.
    function automatic void split_magnitude(input logic [31:0] mag, output int e,
                                            output logic [31:0] sig);
        int lead;
        begin
            if (mag < 32'h0080_0000)
            begin
                lead = 0;
                for (int i = 0; i < 23; i++)
                    if (mag[i]) lead = i;
                e   = lead - 149;
                sig = mag << (-126 - e);
            end
            else
            begin
                e   = int'(mag[30:23]) - 127;
                sig = 32'h0080_0000 | (mag & 32'h007f_ffff);
            end
        end
    endfunction

    // Exact truncated remainder with the sign of x.
    function automatic logic [31:0] fmod_bits(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] sx, hx, hy, mx, my, d;
        int          ex, ey, n, sh;
        begin
            sx = x & SIGN_BIT;
            hx = x & MAG_MASK;
            hy = y & MAG_MASK;
            // Divide by zero, infinite or NaN x, NaN y: quiet NaN, x first.
            if (hy == 0 || hx > LARGEST_FINITE || hy > INF_PATTERN)
            begin
                if (hx > INF_PATTERN) return x | QUIET_BIT;
                if (hy > INF_PATTERN) return y | QUIET_BIT;
                return DEFAULT_NAN;
            end
            if (hx < hy) return x;
            if (hx == hy) return sx;
            split_magnitude(hx, ex, mx);
            split_magnitude(hy, ey, my);
            for (n = ex - ey; n > 0; n--)
            begin
                if (mx < my)
                    mx = mx << 1;
                else
                begin
                    d = mx - my;
                    if (d == 0) return sx;
                    mx = d << 1;
                end
            end
            if (mx >= my) mx = mx - my;
            if (mx == 0) return sx;
            while (mx < 32'h0080_0000)
            begin
                mx = mx << 1;
                ey--;
            end
            if (ey >= -126)
                return (mx - 32'h0080_0000) | (32'(ey + 127) << 23) | sx;
            sh = -126 - ey;
            if (sh > 31) sh = 31;
            return (mx >> sh) | sx;
        end
    endfunction

    task automatic report_mismatch(input string what);
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
            mismatch_count++;
        end
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        begin
            v = $urandom;
            // Bias exponents: many small differences, some subnormals, some specials.
            case ($urandom_range(0, 9))
                0: v[30:23] = 8'd0;
                1: v[30:23] = 8'hff;
                2, 3: v[30:23] = 8'($urandom_range(120, 134));
                default: ;
            endcase
            return v;
        end
    endfunction

    // Driver: hold start high until accepted, then advance to the next item or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start         <= 1'b0;
            dividend_bits <= '0;
            divisor_bits  <= '0;
        end
        else if (!(start && busy))
        begin
            // Either nothing was offered or the offered item was taken this edge.
            if (start)
                expected_remainders.push_back(fmod_bits(dividend_bits, divisor_bits));
            if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start         <= 1'b1;
                dividend_bits <= pending_pairs[0].x;
                divisor_bits  <= pending_pairs[0].y;
                void'(pending_pairs.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every done strobe must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_remainders.size() == 0)
                report_mismatch($sformatf("unexpected result %h", remainder_bits));
            else
            begin
                if (remainder_bits !== expected_remainders[0])
                    report_mismatch($sformatf("remainder_bits got %h want %h",
                                              remainder_bits, expected_remainders[0]));
                void'(expected_remainders.pop_front());
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_remainders.size());
            $display("tb_fp32_remainder_fmod NOT OK");
            $finish;
        end
    end

    task automatic queue_pair(input logic [31:0] x, input logic [31:0] y);
        operand_pair_t p;
        begin
            p.x = x;
            p.y = y;
            pending_pairs.push_back(p);
        end
    endtask

    task automatic queue_random(input int count);
        begin
            for (int i = 0; i < count; i++)
                queue_pair(rand_float(), rand_float());
        end
    endtask

    initial
    begin
        mismatch_count  = 0;
        cycle_count     = 0;
        sender_idle_pct = 32;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: specials, zeros, extremes, subnormals, equal and exact cases.
        queue_pair(32'h7fc0_0001, 32'h7f80_0001);   // NaN x wins over NaN y
        queue_pair(32'hff80_0001, 32'h3f80_0000);   // signaling NaN x gets quieted
        queue_pair(32'h3f80_0000, 32'hffa0_0000);   // NaN y quieted
        queue_pair(32'h7f80_0000, 32'h3f80_0000);   // infinite x
        queue_pair(32'h3f80_0000, 32'h8000_0000);   // zero y
        queue_pair(32'h3f80_0000, 32'h7f80_0000);   // infinite y: x unchanged
        queue_pair(32'h8000_0000, 32'h3f80_0000);   // negative zero x
        queue_pair(32'h0000_0000, 32'h0000_0001);
        queue_pair(32'hc040_0000, 32'h4040_0000);   // equal magnitude
        queue_pair(32'h40c0_0000, 32'h4040_0000);   // exact division
        queue_pair(32'h40e0_0000, 32'hc040_0000);   // 7 mod -3
        queue_pair(32'h7f7f_ffff, 32'h0000_0001);   // widest exponent gap
        queue_pair(32'hff7f_ffff, 32'h0000_0003);
        queue_pair(32'h7f7f_ffff, 32'h007f_ffff);
        queue_pair(32'h0080_0000, 32'h0000_0003);   // subnormal result
        queue_pair(32'h007f_ffff, 32'h0000_0007);
        queue_pair(32'h3f80_0001, 32'h3f80_0000);   // tiny remainder
        queue_pair(32'h7f7f_ffff, 32'h7f7f_fffe);
        queue_pair(32'h0000_0001, 32'h0000_0002);   // smaller dividend
        queue_pair(32'hffff_ffff, 32'h0000_0000);
        queue_pair(32'h5555_5555, 32'haaaa_aaaa);
        queue_pair(32'haaaa_aaaa, 32'h2555_5555);

        queue_random(150);
        wait (pending_pairs.size() == 0 && !start);
        sender_idle_pct = 50;     // receiver cannot stall, only sender pattern varies
        queue_random(140);
        wait (pending_pairs.size() == 0 && !start);
        sender_idle_pct = 0;
        queue_random(140);
        wait (pending_pairs.size() == 0 && !start);

        wait (expected_remainders.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_remainders.size() == 0)
            $display("tb_fp32_remainder_fmod OK");
        else
            $display("tb_fp32_remainder_fmod NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
